// File: hdl/iq_to_stereo_output_formatter_unit_defines.svh
// Assertion macros shared by the IQ to stereo output formatter RTL.
`ifndef IQ_TO_STEREO_OUTPUT_FORMATTER_UNIT_DEFINES_SVH
`define IQ_TO_STEREO_OUTPUT_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication check, disabled while reset is high.
`define IQSF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iqsf: same-cycle check failed");

// Next-cycle implication check, disabled while reset is high.
`define IQSF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iqsf: next-cycle check failed");

`endif

// File: hdl/iqsf_pkg.sv
// Shared types, constants and helper functions of the IQ to stereo formatter.
`default_nettype none
package iqsf_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int FRAC_BITS    = 12;
   localparam int CORDIC_STEPS = 31;
   localparam int SQRT_STEPS   = 24;
   localparam int IDX_W        = $clog2(CORDIC_STEPS);
   localparam int CORDIC_GUARD = 20;
   localparam int ANGLE_FRAC   = 30;
   localparam int XY_W         = 40;
   localparam int Z_W          = 35;
   localparam int RAD_W        = 48;
   localparam int SAT_W        = 48;
   localparam int PHASE_W      = 14;
   localparam int ZP_W         = Z_W + PHASE_W;

   localparam logic signed [Z_W-1:0]     ANGLE_PI    = 35'sd3373259426;
   localparam logic signed [PHASE_W-1:0] PHASE_SCALE = 14'sd5000;

   // Output format codes.
   localparam logic [1:0] FMT_REAL     = 2'd0;
   localparam logic [1:0] FMT_IQ       = 2'd1;
   localparam logic [1:0] FMT_QI       = 2'd2;
   localparam logic [1:0] FMT_ENVPHASE = 2'd3;

   // Register indexes (byte address bit 2).
   localparam logic REG_FORMAT = 1'b0;
   localparam logic REG_GAIN   = 1'b1;

   localparam logic [15:0] GAIN_RESET = 16'd1000;

   // Payload handed from one cell to the next.
   typedef struct packed {
      logic                          zero;
      logic signed [SAMPLE_WIDTH-1:0] re;
      logic signed [SAMPLE_WIDTH-1:0] im;
      logic signed [XY_W-1:0]        x;
      logic signed [XY_W-1:0]        y;
      logic signed [Z_W-1:0]         z;
      logic [RAD_W-1:0]              rem;
      logic [RAD_W-1:0]              root;
   } chain_type;

   // Arctangent of 2^-k in radians with 30 fraction bits, rounded to nearest.
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [IDX_W-1:0] k);
      logic signed [Z_W-1:0] a;
      unique case (k)
         5'd0:    a = 35'sd843314857;
         5'd1:    a = 35'sd497837829;
         5'd2:    a = 35'sd263043837;
         5'd3:    a = 35'sd133525159;
         5'd4:    a = 35'sd67021687;
         5'd5:    a = 35'sd33543516;
         5'd6:    a = 35'sd16775851;
         5'd7:    a = 35'sd8388437;
         5'd8:    a = 35'sd4194283;
         5'd9:    a = 35'sd2097149;
         5'd10:   a = 35'sd1048576;
         5'd11:   a = 35'sd524288;
         5'd12:   a = 35'sd262144;
         5'd13:   a = 35'sd131072;
         5'd14:   a = 35'sd65536;
         5'd15:   a = 35'sd32768;
         5'd16:   a = 35'sd16384;
         5'd17:   a = 35'sd8192;
         5'd18:   a = 35'sd4096;
         5'd19:   a = 35'sd2048;
         5'd20:   a = 35'sd1024;
         5'd21:   a = 35'sd512;
         5'd22:   a = 35'sd256;
         5'd23:   a = 35'sd128;
         5'd24:   a = 35'sd64;
         5'd25:   a = 35'sd32;
         5'd26:   a = 35'sd16;
         5'd27:   a = 35'sd8;
         5'd28:   a = 35'sd4;
         5'd29:   a = 35'sd2;
         5'd30:   a = 35'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

   // Clamp a wide signed value to the signed sample range.
   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_word(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      logic signed [SAMPLE_WIDTH-1:0] r;
      hi = SAT_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
      lo = -SAT_W'(64'sd1 <<< (SAMPLE_WIDTH - 1));
      if (v > hi) begin
         r = hi[SAMPLE_WIDTH-1:0];
      end else if (v < lo) begin
         r = lo[SAMPLE_WIDTH-1:0];
      end else begin
         r = v[SAMPLE_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hdl/iq_to_stereo_output_formatter_unit.sv
// Top level of the IQ to stereo output formatter: register port, cell chain and output skid.
//
//   Channel   Direction  Handshake               Word contents (low bits first)
//   req_      in         req_tvalid/req_tready   in_phase[15:0], quadrature[31:16]
//   rsp_      out        rsp_tvalid/rsp_tready   left_sample[15:0], right_sample[31:16]
//   csr_      in         APB psel/penable        0x0 output_format, 0x4 gain
//
// One word enters per clock when the output side keeps up; after acceptance a word's
// result passes through two input stages, 31 chain cells (one CORDIC step each,
// the first 24 also one square-root bit), two output stages and the output register.
// Reset is synchronous and active high; it clears the valid bits and sets the
// registers to format 0 (real only) and gain 1000.
// When the consumer stalls, the chain keeps running into a one-word skid register
// and holds only once both the output register and the skid register are full.
`default_nettype none
`include "iq_to_stereo_output_formatter_unit_defines.svh"
module iq_to_stereo_output_formatter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // in_phase [15:0], quadrature [31:16]
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // left_sample [15:0], right_sample [31:16]
   // Register port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // ---------------------------------------------------------------------------
   // Configuration registers. Writes land on the access cycle; bit 2 of the
   // byte address picks the register, the lower bits are ignored.
   // ---------------------------------------------------------------------------
   logic [1:0]  fmt_ff, fmt_in;
   logic [15:0] gain_ff, gain_in;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      fmt_in  = fmt_ff;
      gain_in = gain_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            iqsf_pkg::REG_FORMAT: fmt_in  = csr_pwdata[1:0];
            iqsf_pkg::REG_GAIN:   gain_in = csr_pwdata[15:0];
            default:              fmt_in  = fmt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= iqsf_pkg::FMT_REAL;
         gain_ff <= iqsf_pkg::GAIN_RESET;
      end else begin
         fmt_ff  <= fmt_in;
         gain_ff <= gain_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         iqsf_pkg::REG_FORMAT: csr_prdata = {30'd0, fmt_ff};
         iqsf_pkg::REG_GAIN:   csr_prdata = {16'd0, gain_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Datapath. Every stage advances together whenever the skid register is free,
   // so the ready toward the source comes straight from a flop.
   // ---------------------------------------------------------------------------
   logic skid_vld_ff, skid_vld_in;
   logic pipe_en;

   assign pipe_en    = !skid_vld_ff;
   assign req_tready = pipe_en;

   logic                front_vld;
   iqsf_pkg::chain_type front_data;

   iqsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .in_vld     (req_tvalid && req_tready),
      .in_phase   ($signed(req_tdata[15:0])),
      .quadrature ($signed(req_tdata[31:16])),
      .gain       (gain_ff),
      .out_vld    (front_vld),
      .out_data   (front_data)
   );

   // Row of cells; cell k performs CORDIC step k.
   logic                chain_vld  [iqsf_pkg::CORDIC_STEPS+1];
   iqsf_pkg::chain_type chain_data [iqsf_pkg::CORDIC_STEPS+1];

   assign chain_vld[0]  = front_vld;
   assign chain_data[0] = front_data;

   for (genvar k = 0; k < iqsf_pkg::CORDIC_STEPS; k++) begin : g_cell
      iqsf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .cell_idx (iqsf_pkg::IDX_W'(k)),
         .in_vld   (chain_vld[k]),
         .in_data  (chain_data[k]),
         .out_vld  (chain_vld[k+1]),
         .out_data (chain_data[k+1])
      );
   end

   logic                                 back_vld;
   logic signed [iqsf_pkg::SAMPLE_WIDTH-1:0] back_left, back_right;

   iqsf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .en            (pipe_en),
      .output_format (fmt_ff),
      .in_vld        (chain_vld[iqsf_pkg::CORDIC_STEPS]),
      .in_data       (chain_data[iqsf_pkg::CORDIC_STEPS]),
      .out_vld       (back_vld),
      .out_left      (back_left),
      .out_right     (back_right)
   );

   // ---------------------------------------------------------------------------
   // Output register plus skid register. A word leaving the chain while the
   // output register is full and not being taken parks in the skid register,
   // which then holds the chain until the output register drains.
   // ---------------------------------------------------------------------------
   logic        rsp_vld_ff, rsp_vld_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [31:0] skid_data_ff, skid_data_in;
   logic        rsp_take;
   logic        chain_out;

   assign rsp_take  = rsp_vld_ff && rsp_tready;
   assign chain_out = pipe_en && back_vld;

   always_comb begin
      rsp_vld_in   = rsp_vld_ff;
      rsp_data_in  = rsp_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (skid_vld_ff) begin
         if (rsp_take) begin
            rsp_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end
      end else if (chain_out) begin
         if (!rsp_vld_ff || rsp_take) begin
            rsp_vld_in  = 1'b1;
            rsp_data_in = {back_right, back_left};
         end else begin
            skid_vld_in  = 1'b1;
            skid_data_in = {back_right, back_left};
         end
      end else if (rsp_take) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------------
   // Checks on the output buffering.
   // ---------------------------------------------------------------------------
   `IQSF_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_vld_ff, rsp_vld_ff)
   `IQSF_ASSERT_IMP(a_skid_fill_on_stall, clock, reset, $rose(skid_vld_ff), $past(rsp_vld_ff && !rsp_tready))
   `IQSF_ASSERT_IMP(a_skid_drain_on_take, clock, reset, $fell(skid_vld_ff), $past(rsp_tready))
   `IQSF_ASSERT_NXT(a_skid_refills_out, clock, reset, skid_vld_ff && rsp_tready, rsp_vld_ff)

endmodule
`default_nettype wire

// File: hdl/iqsf_front.sv
// Input stages: gain and square products, then scaling and CORDIC/root setup.
`default_nettype none
module iqsf_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_vld,
   input  wire logic signed [iqsf_pkg::SAMPLE_WIDTH-1:0] in_phase,
   input  wire logic signed [iqsf_pkg::SAMPLE_WIDTH-1:0] quadrature,
   input  wire logic [15:0]                          gain,
   output logic                                      out_vld,
   output iqsf_pkg::chain_type                       out_data
);

   localparam int PROD_W = 33;
   localparam int SQ_W   = 32;

   // First stage: all four products.
   logic                     a_vld_ff;
   logic signed [PROD_W-1:0] a_re_ff, a_re_in;
   logic signed [PROD_W-1:0] a_im_ff, a_im_in;
   logic [SQ_W-1:0]          a_ii_ff, a_ii_in;
   logic [SQ_W-1:0]          a_qq_ff, a_qq_in;
   logic signed [15:0]       a_i_ff;
   logic signed [15:0]       a_q_ff;

   // Second stage: chain entry.
   logic                out_vld_ff;
   iqsf_pkg::chain_type out_data_ff, out_data_in;

   logic signed [PROD_W-1:0] gain_s;
   logic signed [SQ_W-1:0]   ii_s, qq_s;
   logic signed [PROD_W-1:0] re_rnd, im_rnd;
   logic signed [PROD_W-1:0] re_q, im_q;
   logic [SQ_W-1:0]          mag_sq;
   logic signed [iqsf_pkg::XY_W-1:0] x0, y0;

   always_comb begin
      gain_s  = PROD_W'($signed({1'b0, gain}));
      a_re_in = PROD_W'(in_phase) * gain_s;
      a_im_in = PROD_W'(quadrature) * gain_s;
      ii_s    = SQ_W'(in_phase) * SQ_W'(in_phase);
      qq_s    = SQ_W'(quadrature) * SQ_W'(quadrature);
      a_ii_in = ii_s;
      a_qq_in = qq_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_re_ff <= a_re_in;
         a_im_ff <= a_im_in;
         a_ii_ff <= a_ii_in;
         a_qq_ff <= a_qq_in;
         a_i_ff  <= in_phase;
         a_q_ff  <= quadrature;
      end
   end

   always_comb begin
      // Truncation toward zero: bias negative values before the shift.
      re_rnd = a_re_ff + (a_re_ff[PROD_W-1] ? PROD_W'((1 << iqsf_pkg::FRAC_BITS) - 1)
                                              : PROD_W'(0));
      im_rnd = a_im_ff + (a_im_ff[PROD_W-1] ? PROD_W'((1 << iqsf_pkg::FRAC_BITS) - 1)
                                              : PROD_W'(0));
      re_q   = re_rnd >>> iqsf_pkg::FRAC_BITS;
      im_q   = im_rnd >>> iqsf_pkg::FRAC_BITS;
      mag_sq = a_ii_ff + a_qq_ff;
      x0     = iqsf_pkg::XY_W'(a_i_ff) <<< iqsf_pkg::CORDIC_GUARD;
      y0     = iqsf_pkg::XY_W'(a_q_ff) <<< iqsf_pkg::CORDIC_GUARD;

      out_data_in.re   = iqsf_pkg::sat_word(iqsf_pkg::SAT_W'(re_q));
      out_data_in.im   = iqsf_pkg::sat_word(iqsf_pkg::SAT_W'(im_q));
      out_data_in.zero = (a_i_ff == '0) && (a_q_ff == '0);
      out_data_in.rem  = {mag_sq, 16'd0};
      out_data_in.root = '0;
      // Left half plane is folded over by negation, starting the angle at +/- pi.
      if (a_i_ff[15]) begin
         out_data_in.x = -x0;
         out_data_in.y = -y0;
         out_data_in.z = a_q_ff[15] ? -iqsf_pkg::ANGLE_PI : iqsf_pkg::ANGLE_PI;
      end else begin
         out_data_in.x = x0;
         out_data_in.y = y0;
         out_data_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_data = out_data_ff;

endmodule
`default_nettype wire

// File: hdl/iqsf_cell.sv
// One chain cell: a vectoring CORDIC step and, in the first cells, a root digit step.
`default_nettype none
module iqsf_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic [iqsf_pkg::IDX_W-1:0]  cell_idx,
   input  wire logic                        in_vld,
   input  wire iqsf_pkg::chain_type         in_data,
   output logic                             out_vld,
   output iqsf_pkg::chain_type              out_data
);

   logic                out_vld_ff;
   iqsf_pkg::chain_type out_data_ff, out_data_in;

   logic signed [iqsf_pkg::XY_W-1:0] x_cur, y_cur, x_sh, y_sh;
   logic [5:0]                       bit_pos;
   logic [iqsf_pkg::RAD_W-1:0]       bit_val, trial;

   always_comb begin
      x_cur   = in_data.x;
      y_cur   = in_data.y;
      x_sh    = x_cur >>> cell_idx;
      y_sh    = y_cur >>> cell_idx;
      bit_pos = 6'(2 * (iqsf_pkg::SQRT_STEPS - 1)) - {cell_idx, 1'b0};
      bit_val = iqsf_pkg::RAD_W'(1) << bit_pos;
      trial   = in_data.root + bit_val;

      out_data_in = in_data;
      // Rotate toward the positive real axis.
      if (!y_cur[iqsf_pkg::XY_W-1]) begin
         out_data_in.x = x_cur + y_sh;
         out_data_in.y = y_cur - x_sh;
         out_data_in.z = in_data.z + iqsf_pkg::atan_entry(cell_idx);
      end else begin
         out_data_in.x = x_cur - y_sh;
         out_data_in.y = y_cur + x_sh;
         out_data_in.z = in_data.z - iqsf_pkg::atan_entry(cell_idx);
      end

      // Restoring square root, one result bit per cell.
      if (cell_idx < iqsf_pkg::IDX_W'(iqsf_pkg::SQRT_STEPS)) begin
         if (in_data.rem >= trial) begin
            out_data_in.rem  = in_data.rem - trial;
            out_data_in.root = (in_data.root >> 1) + bit_val;
         end else begin
            out_data_in.root = in_data.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_data = out_data_ff;

endmodule
`default_nettype wire

// File: hdl/iqsf_back.sv
// Output stages: phase scaling, envelope extraction and the stereo format select.
`default_nettype none
module iqsf_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic [1:0]                           output_format,
   input  wire logic                                 in_vld,
   input  wire iqsf_pkg::chain_type                  in_data,
   output logic                                      out_vld,
   output logic signed [iqsf_pkg::SAMPLE_WIDTH-1:0]  out_left,
   output logic signed [iqsf_pkg::SAMPLE_WIDTH-1:0]  out_right
);

   localparam int PH_W = iqsf_pkg::ZP_W - iqsf_pkg::ANGLE_FRAC;

   logic                                 c_vld_ff;
   logic signed [iqsf_pkg::ZP_W-1:0]     c_zp_ff, c_zp_in;
   logic                                 c_zero_ff;
   logic signed [iqsf_pkg::SAMPLE_WIDTH-1:0] c_re_ff, c_im_ff;
   logic [iqsf_pkg::SQRT_STEPS-1:0]      c_root_ff;

   logic                                 out_vld_ff;
   logic signed [iqsf_pkg::SAMPLE_WIDTH-1:0] left_ff, left_in;
   logic signed [iqsf_pkg::SAMPLE_WIDTH-1:0] right_ff, right_in;

   logic signed [iqsf_pkg::ZP_W-1:0]     zp_rnd;
   logic signed [PH_W-1:0]               ph_q;
   logic signed [iqsf_pkg::SAMPLE_WIDTH-1:0] phase, env;

   assign c_zp_in = iqsf_pkg::ZP_W'(in_data.z) * iqsf_pkg::ZP_W'(iqsf_pkg::PHASE_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_zp_ff   <= c_zp_in;
         c_zero_ff <= in_data.zero;
         c_re_ff   <= in_data.re;
         c_im_ff   <= in_data.im;
         c_root_ff <= in_data.root[iqsf_pkg::SQRT_STEPS-1:0];
      end
   end

   always_comb begin
      zp_rnd = c_zp_ff + (c_zp_ff[iqsf_pkg::ZP_W-1]
                          ? iqsf_pkg::ZP_W'((64'sd1 <<< iqsf_pkg::ANGLE_FRAC) - 64'sd1)
                          : iqsf_pkg::ZP_W'(0));
      ph_q   = PH_W'(zp_rnd >>> iqsf_pkg::ANGLE_FRAC);
      // The rotation never settles for a zero sample, so its angle is forced.
      phase  = c_zero_ff ? '0 : iqsf_pkg::sat_word(iqsf_pkg::SAT_W'(ph_q));
      env    = iqsf_pkg::sat_word(iqsf_pkg::SAT_W'(c_root_ff >> iqsf_pkg::FRAC_BITS));

      unique case (output_format)
         iqsf_pkg::FMT_REAL: begin
            left_in  = c_re_ff;
            right_in = '0;
         end
         iqsf_pkg::FMT_IQ: begin
            left_in  = c_re_ff;
            right_in = c_im_ff;
         end
         iqsf_pkg::FMT_QI: begin
            left_in  = c_im_ff;
            right_in = c_re_ff;
         end
         default: begin
            left_in  = env;
            right_in = phase;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign out_vld   = out_vld_ff;
   assign out_left  = left_ff;
   assign out_right = right_ff;

endmodule
`default_nettype wire

// File: tb/sv/tb_iq_to_stereo_output_formatter_unit.sv
// Self-checking testbench for the IQ to stereo output formatter with a built-in predictor.
`timescale 1ns / 100ps
module tb_iq_to_stereo_output_formatter_unit;

   // The watchdog ends the run after this many cycles in a row with no handshake.
   // The slowest correct stretch is the LONG_HOLD consumer hold-off plus the
   // pipeline latency, so this leaves a wide margin.
   localparam int STALL_LIMIT   = 4000;
   localparam int LONG_HOLD     = 200;
   localparam int TAIL_CYCLES   = 48;
   localparam int PHASES        = 12;
   localparam int PHASE_WORDS   = 160;
   localparam longint HALF_TURN = 64'sd3373259426;

   // Sample word on req_tdata and result word on rsp_tdata, low field in the low bits.
   typedef struct packed {
      logic signed [15:0] quadrature;
      logic signed [15:0] in_phase;
   } iq_word_type;

   typedef struct packed {
      logic signed [15:0] right_sample;
      logic signed [15:0] left_sample;
   } stereo_word_type;

   // One directed stimulus row: the register setting it runs under, the sample,
   // and, where it is obvious, the stereo pair typed in by hand.
   typedef struct {
      logic [1:0]      fmt;
      logic [15:0]     gain;
      iq_word_type     sample;
      bit              typed;
      stereo_word_type pair;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Register shadow used by the predictor. It only changes while the block is idle.
   logic [1:0]  fmt_now;
   logic [15:0] gain_now;

   stereo_word_type  pending_pairs[$];
   directed_row_type directed_rows[$];

   // Arctangent of 2^-k in radians with 30 fraction bits, rounded to nearest.
   longint atan_rad30 [0:30] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
      128, 64, 32, 16, 8, 4, 2, 1
   };

   int  errors       = 0;
   int  words_sent   = 0;
   int  words_seen   = 0;
   int  settings_run = 1;
   int  fmt_hits [0:3] = '{0, 0, 0, 0};
   int  req_gap_max  = 5;
   int  rsp_gap_max  = 5;
   bit  long_hold_request = 1'b0;
   int  quiet_cycles = 0;

   iq_to_stereo_output_formatter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor.
   // ------------------------------------------------------------------

   // Divide by 2^s, truncating toward zero as a C integer division would.
   function automatic longint shift_toward_zero(input longint v, input int s);
      if (v < 0) begin
         return -((-v) >>> s);
      end
      return v >>> s;
   endfunction

   function automatic longint clamp_sample(input longint v);
      if (v > 32767) begin
         return 32767;
      end else if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   // Bit-by-bit integer square root, floor of the exact root.
   function automatic longint floor_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) begin
         b = b >> 2;
      end
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   // atan2(q, i) in radians times 5000 from a 31-step vectoring CORDIC. Samples
   // left of the imaginary axis are mirrored first and start from plus or minus
   // pi, with the negative real axis starting from plus pi.
   function automatic longint phase_scaled(input longint i_val, input longint q_val);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      if (i_val == 0 && q_val == 0) begin
         return 0;
      end
      x = i_val <<< 20;
      y = q_val <<< 20;
      z = 0;
      if (i_val < 0) begin
         x = -x;
         y = -y;
         z = (q_val >= 0) ? HALF_TURN : -HALF_TURN;
      end
      for (int k = 0; k < 31; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_rad30[k];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_rad30[k];
         end
      end
      return clamp_sample(shift_toward_zero(z * 5000, 30));
   endfunction

   // Stereo pair that the block must produce for one sample under the current setting.
   function automatic stereo_word_type stereo_pair_of(input iq_word_type s);
      stereo_word_type p;
      longint          i_val;
      longint          q_val;
      longint          re;
      longint          im;
      longint unsigned power;
      i_val = longint'(s.in_phase);
      q_val = longint'(s.quadrature);
      re = clamp_sample(shift_toward_zero(i_val * longint'(gain_now), iqsf_pkg::FRAC_BITS));
      im = clamp_sample(shift_toward_zero(q_val * longint'(gain_now), iqsf_pkg::FRAC_BITS));
      case (fmt_now)
         iqsf_pkg::FMT_REAL: begin
            p.left_sample  = 16'(re);
            p.right_sample = '0;
         end
         iqsf_pkg::FMT_IQ: begin
            p.left_sample  = 16'(re);
            p.right_sample = 16'(im);
         end
         iqsf_pkg::FMT_QI: begin
            p.left_sample  = 16'(im);
            p.right_sample = 16'(re);
         end
         default: begin
            // Envelope: floor(|sample| * 256) through the scaled square root, shifted right by FRAC_BITS.
            power = longint'(i_val * i_val + q_val * q_val);
            p.left_sample  = 16'(clamp_sample(floor_sqrt(power << 16) >>>
                                              iqsf_pkg::FRAC_BITS));
            p.right_sample = 16'(phase_scaled(i_val, q_val));
         end
      endcase
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Register port.
   // ------------------------------------------------------------------

   // One APB transfer: setup cycle, then access cycle until pready.
   task automatic csr_access(input logic wr, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Compare a register read against the value it must hold.
   task automatic check_register(input logic [2:0] addr, input logic [31:0] want);
      logic [31:0] got;
      csr_access(1'b0, addr, '0, got);
      if (got !== want) begin
         $error("register 0x%0h readback mismatch: expected %0d, got %0d", addr, want, got);
         errors++;
      end
   endtask

   // Write a register with junk in the bits above its width; only the low bits
   // may land, and the readback must show the masked value.
   task automatic write_register(input logic [2:0] addr, input logic [15:0] value,
                                 input int width);
      logic [31:0] junk;
      logic [31:0] masked;
      junk   = $urandom();
      masked = 32'(value) & ((32'd1 << width) - 32'd1);
      csr_access(1'b1, addr, (junk & ~((32'd1 << width) - 32'd1)) | masked, junk);
      check_register(addr, masked);
   endtask

   // ------------------------------------------------------------------
   // Input side.
   // ------------------------------------------------------------------

   // Drop valid and wait until every word sent so far has come back.
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pairs.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Move to a new register setting. Writes only happen with the block empty.
   task automatic apply_setting(input logic [1:0] fmt, input logic [15:0] gain);
      if (fmt != fmt_now || gain != gain_now) begin
         drain_pipeline();
         if (fmt != fmt_now) begin
            write_register({iqsf_pkg::REG_FORMAT, 2'b00}, 16'(fmt), 2);
            fmt_now = fmt;
         end
         if (gain != gain_now) begin
            write_register({iqsf_pkg::REG_GAIN, 2'b00}, gain, 16);
            gain_now = gain;
         end
         settings_run++;
      end
   endtask

   // Offer one sample word after a random gap. Valid stays high across back-to-back
   // words, so a zero gap only replaces the data. The expected pair is queued at
   // acceptance, either the hand-typed one or the predictor's.
   task automatic offer_sample(input iq_word_type s, input bit typed,
                               input stereo_word_type pair);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      pending_pairs.push_back(typed ? pair : stereo_pair_of(s));
      fmt_hits[fmt_now]++;
      words_sent++;
   endtask

   task automatic add_row(input logic [1:0] fmt, input logic [15:0] gain,
                          input logic signed [15:0] i_in, input logic signed [15:0] q_in,
                          input bit typed, input logic signed [15:0] left,
                          input logic signed [15:0] right);
      directed_row_type r;
      r.fmt                = fmt;
      r.gain               = gain;
      r.sample.in_phase    = i_in;
      r.sample.quadrature  = q_in;
      r.typed              = typed;
      r.pair.left_sample   = left;
      r.pair.right_sample  = right;
      directed_rows.push_back(r);
   endtask

   // Random sample with a bias toward the corners: extremes, axes, both diagonals,
   // tiny values and the negative real axis, alongside plain full-range words.
   function automatic iq_word_type draw_sample();
      iq_word_type s;
      logic signed [15:0] corner [0:5];
      corner = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
      s = $urandom();
      case ($urandom_range(0, 9))
         5: begin
            s.in_phase   = 16'($signed($urandom_range(0, 128)) - 64);
            s.quadrature = 16'($signed($urandom_range(0, 128)) - 64);
         end
         6: begin
            s.in_phase   = corner[$urandom_range(0, 5)];
            s.quadrature = corner[$urandom_range(0, 5)];
         end
         7: begin
            if ($urandom_range(0, 1) == 1) begin
               s.in_phase = '0;
            end else begin
               s.quadrature = '0;
            end
         end
         8: begin
            s.quadrature = ($urandom_range(0, 1) == 1) ? s.in_phase : -s.in_phase;
         end
         9: begin
            s.in_phase   = -16'(16'($urandom_range(1, 32768)));
            s.quadrature = '0;
         end
         default: begin
         end
      endcase
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Output side: random ready gaps, one long hold-off on request, and a
   // field-by-field check of every accepted result word.
   // ------------------------------------------------------------------
   initial begin : result_side
      int              hold;
      stereo_word_type got;
      stereo_word_type want;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         hold = $urandom_range(0, rsp_gap_max);
         if (long_hold_request) begin
            hold = LONG_HOLD;
            long_hold_request = 1'b0;
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = rsp_tdata;
         words_seen++;
         if (pending_pairs.size() == 0) begin
            $error("result word 0x%08h arrived with nothing expected", rsp_tdata);
            errors++;
         end else begin
            want = pending_pairs.pop_front();
            if (got.left_sample !== want.left_sample) begin
               $error("left_sample mismatch: expected %0d, got %0d",
                      want.left_sample, got.left_sample);
               errors++;
            end
            if (got.right_sample !== want.right_sample) begin
               $error("right_sample mismatch: expected %0d, got %0d",
                      want.right_sample, got.right_sample);
               errors++;
            end
         end
      end
   end

   // Watchdog: any handshake on any port restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Timed out after %0d cycles without a handshake.", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin : stimulus
      stereo_word_type none;
      logic [1:0]      fmt;
      logic [15:0]     gain;
      none        = '0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      fmt_now     = iqsf_pkg::FMT_REAL;
      gain_now    = iqsf_pkg::GAIN_RESET;

      // Directed rows. The first ones run on the reset setting, so they also
      // prove that real-only format and a gain of 1000 come out of reset.
      add_row(iqsf_pkg::FMT_REAL, 16'd1000, 16'sd4096, 16'sd0, 1, 16'sd1000, 16'sd0);
      add_row(iqsf_pkg::FMT_REAL, 16'd1000, -16'sd4096, 16'sd4096, 1, -16'sd1000, 16'sd0);
      add_row(iqsf_pkg::FMT_REAL, 16'd1000, 16'sd0, 16'sd0, 1, 16'sd0, 16'sd0);
      // Full gain on full-scale words must clip at both rails.
      add_row(iqsf_pkg::FMT_REAL, 16'd65535, 16'sd32767, -16'sd32768, 1, 16'sd32767, 16'sd0);
      add_row(iqsf_pkg::FMT_REAL, 16'd65535, -16'sd32768, 16'sd32767, 1, -16'sd32768, 16'sd0);
      add_row(iqsf_pkg::FMT_IQ, 16'd65535, 16'sd32767, -16'sd32768, 1, 16'sd32767,
              -16'sd32768);
      add_row(iqsf_pkg::FMT_IQ, 16'd65535, -16'sd32768, 16'sd32767, 1, -16'sd32768,
              16'sd32767);
      add_row(iqsf_pkg::FMT_IQ, 16'd0, 16'sd12345, -16'sd12345, 1, 16'sd0, 16'sd0);
      // A gain of 4096 passes the raw words through, with the channels swapped.
      add_row(iqsf_pkg::FMT_QI, 16'd4096, 16'sd1234, -16'sd5678, 1, -16'sd5678, 16'sd1234);
      add_row(iqsf_pkg::FMT_QI, 16'd4096, -16'sd1, 16'sd1, 1, 16'sd1, -16'sd1);
      // Truncation goes toward zero for both signs.
      add_row(iqsf_pkg::FMT_QI, 16'd1, -16'sd4095, 16'sd4095, 1, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_QI, 16'd1, -16'sd32768, 16'sd32767, 1, 16'sd7, -16'sd8);
      // Envelope and phase: the zero sample, the axes including the negative
      // real axis, the diagonals and the full-scale corners.
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, 16'sd0, 16'sd0, 1, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, 16'sd4096, 16'sd0, 0, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, -16'sd4096, 16'sd0, 0, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, -16'sd4096, -16'sd1, 0, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, 16'sd0, 16'sd4096, 0, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, 16'sd0, -16'sd4096, 0, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, 16'sd32767, 16'sd32767, 0, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, -16'sd32768, -16'sd32768, 0, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, -16'sd32768, 16'sd0, 0, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, 16'sd1, -16'sd1, 0, 16'sd0, 16'sd0);
      add_row(iqsf_pkg::FMT_ENVPHASE, 16'd1, -16'sd1, 16'sd0, 0, 16'sd0, 16'sd0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Both registers must read back their reset values.
      check_register({iqsf_pkg::REG_FORMAT, 2'b00}, 32'(iqsf_pkg::FMT_REAL));
      check_register({iqsf_pkg::REG_GAIN, 2'b00}, 32'(iqsf_pkg::GAIN_RESET));

      foreach (directed_rows[n]) begin
         apply_setting(directed_rows[n].fmt, directed_rows[n].gain);
         offer_sample(directed_rows[n].sample, directed_rows[n].typed,
                      directed_rows[n].pair);
      end

      // Random phases. The first eight walk every format against a spread of
      // gains; later ones pick the format at random.
      for (int ph = 0; ph < PHASES; ph++) begin
         fmt = (ph < 8) ? 2'(ph % 4) : 2'($urandom_range(0, 3));
         case (ph % 6)
            0:       gain = 16'd65535;
            1:       gain = 16'd1;
            2:       gain = 16'd0;
            3:       gain = 16'($urandom_range(0, 65535));
            4:       gain = 16'($urandom_range(1, 8191));
            default: gain = 16'd4096;
         endcase
         apply_setting(fmt, gain);
         // A few phases run with no idling on either side.
         if (ph == 3 || ph == 7 || ph == 10) begin
            req_gap_max = 0;
            rsp_gap_max = 0;
         end else begin
            req_gap_max = 5;
            rsp_gap_max = 5;
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // With words offered every cycle, a long consumer hold-off fills
            // the pipeline and the skid register and must back up req_tready.
            if (ph == 3 && n == 10) begin
               long_hold_request = 1'b1;
            end
            // The producer stops mid-phase until every result is back.
            if (ph == 5 && n == 80) begin
               drain_pipeline();
            end
            offer_sample(draw_sample(), 1'b0, none);
         end
      end

      drain_pipeline();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d sample words and checked %0d result words under %0d register settings.",
               words_sent, words_seen, settings_run);
      $display("Words per format: real %0d, I/Q %0d, Q/I %0d, envelope/phase %0d.",
               fmt_hits[iqsf_pkg::FMT_REAL], fmt_hits[iqsf_pkg::FMT_IQ],
               fmt_hits[iqsf_pkg::FMT_QI], fmt_hits[iqsf_pkg::FMT_ENVPHASE]);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
